// File: design/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg: shared constants and types for the task dependency trigger
// Table sizes, field widths, command and result codes, counter unit types.
// ----------------------------------------------------------------------------
package tdt_pkg;

   localparam int NUM_TASKS   = 64;
   localparam int NUM_FUTURES = 64;
   localparam int MAX_OUTS    = 4;
   localparam int MAX_WAITERS = 8;
   localparam int COUNT_MAX   = 127;

   localparam int CMD_W  = 2;
   localparam int TASK_W = 6;
   localparam int FUT_W  = 6;
   localparam int KIND_W = 2;
   localparam int CNT_W  = 7;

   localparam int OLEN_W   = $clog2(MAX_OUTS + 1);
   localparam int WLEN_W   = $clog2(MAX_WAITERS + 1);
   localparam int TID_IW   = $clog2(NUM_TASKS);
   localparam int FID_IW   = $clog2(NUM_FUTURES);
   localparam int OL_DEPTH = NUM_TASKS * MAX_OUTS;
   localparam int WL_DEPTH = NUM_FUTURES * MAX_WAITERS;
   localparam int OL_AW    = $clog2(OL_DEPTH);
   localparam int WL_AW    = $clog2(WL_DEPTH);

   localparam logic [CMD_W-1:0] CMD_LINK_OUT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LINK_WAIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ISSUE     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COMPLETE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ISSUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   localparam logic ALU_INC = 1'b0;
   localparam logic ALU_DEC = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0] sum;
      logic             at_zero;
      logic             at_max;
      logic             sum_zero;
   } alu_res_type;

endpackage

// File: design/tdt_ram.sv
// ----------------------------------------------------------------------------
// tdt_ram: simple dual-port table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tdt_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = q_ff;

endmodule

// File: design/tdt_alu.sv
// ----------------------------------------------------------------------------
// tdt_alu: pending count unit
// Increment or decrement of a pending count with limit and zero flags.
// ----------------------------------------------------------------------------
module tdt_alu import tdt_pkg::*; (
   input  logic             alu_op,
   input  logic [CNT_W-1:0] operand,
   output alu_res_type      res
);

   always_comb begin
      if (alu_op == ALU_INC) begin
         res.sum = operand + CNT_W'(1);
      end else begin
         res.sum = operand - CNT_W'(1);
      end
      res.at_zero  = (operand == '0);
      res.at_max   = (operand >= CNT_W'(COUNT_MAX));
      res.sum_zero = (res.sum == '0);
   end

endmodule

// File: design/task_dependency_trigger.sv
// ----------------------------------------------------------------------------
// task_dependency_trigger: dependency-counting task trigger engine
// Commands on the req_ channel link futures to tasks, issue tasks and
// complete tasks; results (done, issue, error) leave on the rsp_ channel.
//
// Both channels move a transaction when valid is high and stall is low.
// req_stall is high from the cycle after a transaction is taken until the
// command's last result has been loaded into the output register.
// Link and issue commands give one result, loaded into the output register
// from S_FINAL after S_LOOK; the next request can be taken only once the
// block is back in S_IDLE, so a command is finished before the next is taken.
// Complete walks the task's output list: per future S_OREAD, S_FREAD and
// S_FDEC (list read, count read, count write through the shared count unit),
// then S_WREAD and S_WEMIT per waiter released, then the final done result.
// Each list, length and count table is a single-port-read memory; its
// registered read data sets the state sequence above.
// While rsp_stall is high the held result stays put and S_WEMIT/S_FINAL wait.
// Reset clears all pending counts and list lengths at once through per
// entry valid bits; list contents are not cleared.
// ----------------------------------------------------------------------------
module task_dependency_trigger import tdt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [TASK_W-1:0] req_task_id,
   input  logic [FUT_W-1:0]  req_future_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_result_kind,
   output logic [TASK_W-1:0] rsp_issued_task,
   output logic              rsp_last_item
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOOK  = 3'd1;
   localparam logic [2:0] S_OREAD = 3'd2;
   localparam logic [2:0] S_FREAD = 3'd3;
   localparam logic [2:0] S_FDEC  = 3'd4;
   localparam logic [2:0] S_WREAD = 3'd5;
   localparam logic [2:0] S_WEMIT = 3'd6;
   localparam logic [2:0] S_FINAL = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [TASK_W-1:0] tid_ff, tid_in;
   logic [FUT_W-1:0]  fu_ff, fu_in;
   logic [OLEN_W-1:0] idx_ff, idx_in;
   logic [WLEN_W-1:0] j_ff, j_in;
   logic [OLEN_W-1:0] olen_ff, olen_in;
   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [KIND_W-1:0] fin_kind_ff, fin_kind_in;
   logic [TASK_W-1:0] fin_task_ff, fin_task_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [TASK_W-1:0] rsp_task_ff, rsp_task_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [NUM_TASKS-1:0]   oln_vld_ff;
   logic [NUM_FUTURES-1:0] pc_vld_ff;
   logic [NUM_FUTURES-1:0] wln_vld_ff;
   logic                   oln_vld_q_ff, pc_vld_q_ff, wln_vld_q_ff;

   // table ports
   logic              oln_we;
   logic [TID_IW-1:0] oln_waddr, oln_raddr;
   logic [OLEN_W-1:0] oln_wdata, oln_q;
   logic              pc_we;
   logic [FID_IW-1:0] pc_waddr, pc_raddr;
   logic [CNT_W-1:0]  pc_wdata, pc_q;
   logic              wln_we;
   logic [FID_IW-1:0] wln_waddr, wln_raddr;
   logic [WLEN_W-1:0] wln_wdata, wln_q;
   logic              ols_we;
   logic [OL_AW-1:0]  ols_waddr, ols_raddr;
   logic [FUT_W-1:0]  ols_wdata, ols_q;
   logic              wls_we;
   logic [WL_AW-1:0]  wls_waddr, wls_raddr;
   logic [TASK_W-1:0] wls_wdata, wls_q;

   logic [TID_IW-1:0] tid_idx;
   logic [FID_IW-1:0] fu_idx;
   logic [OLEN_W-1:0] olen_eff, idx_nxt;
   logic [CNT_W-1:0]  pcnt_eff;
   logic [WLEN_W-1:0] wlen_eff, j_nxt;
   logic              tid_bad, fid_bad, fu_ok, last_out, can_emit;
   logic              alu_op;
   alu_res_type       alu_res;

   tdt_ram #(.DEPTH(NUM_TASKS), .WIDTH(OLEN_W)) u_out_len (
      .clock(clock), .wr_en(oln_we), .wr_addr(oln_waddr), .wr_data(oln_wdata),
      .rd_addr(oln_raddr), .rd_data(oln_q)
   );

   tdt_ram #(.DEPTH(NUM_FUTURES), .WIDTH(CNT_W)) u_pend_cnt (
      .clock(clock), .wr_en(pc_we), .wr_addr(pc_waddr), .wr_data(pc_wdata),
      .rd_addr(pc_raddr), .rd_data(pc_q)
   );

   tdt_ram #(.DEPTH(NUM_FUTURES), .WIDTH(WLEN_W)) u_wait_len (
      .clock(clock), .wr_en(wln_we), .wr_addr(wln_waddr), .wr_data(wln_wdata),
      .rd_addr(wln_raddr), .rd_data(wln_q)
   );

   tdt_ram #(.DEPTH(OL_DEPTH), .WIDTH(FUT_W)) u_out_list (
      .clock(clock), .wr_en(ols_we), .wr_addr(ols_waddr), .wr_data(ols_wdata),
      .rd_addr(ols_raddr), .rd_data(ols_q)
   );

   tdt_ram #(.DEPTH(WL_DEPTH), .WIDTH(TASK_W)) u_wait_list (
      .clock(clock), .wr_en(wls_we), .wr_addr(wls_waddr), .wr_data(wls_wdata),
      .rd_addr(wls_raddr), .rd_data(wls_q)
   );

   tdt_alu u_alu (
      .alu_op(alu_op), .operand(pcnt_eff), .res(alu_res)
   );

   assign tid_idx = TID_IW'(tid_ff);
   assign fu_idx  = FID_IW'(fu_ff);

   // length and count reads are issued straight from the request on the accepting edge
   assign oln_raddr = (state_ff == S_IDLE) ? TID_IW'(req_task_id) : tid_idx;
   always_comb begin
      if (state_ff == S_IDLE) begin
         pc_raddr = FID_IW'(req_future_id);
      end else if (state_ff == S_FREAD) begin
         pc_raddr = FID_IW'(ols_q);
      end else begin
         pc_raddr = fu_idx;
      end
   end
   assign wln_raddr = pc_raddr;
   assign ols_raddr = OL_AW'(int'(tid_idx) * MAX_OUTS + int'(idx_ff));
   assign wls_raddr = WL_AW'(int'(fu_idx) * MAX_WAITERS + int'(j_ff));

   // entries never written since reset read as zero
   assign olen_eff = oln_vld_q_ff ? oln_q : '0;
   assign pcnt_eff = pc_vld_q_ff  ? pc_q  : '0;
   assign wlen_eff = wln_vld_q_ff ? wln_q : '0;

   assign tid_bad  = (int'(tid_ff) >= NUM_TASKS);
   assign fid_bad  = (int'(fu_ff) >= NUM_FUTURES);
   assign fu_ok    = (int'(fu_ff) < NUM_FUTURES);
   assign idx_nxt  = idx_ff + OLEN_W'(1);
   assign j_nxt    = j_ff + WLEN_W'(1);
   assign last_out = (idx_nxt >= olen_ff);
   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign alu_op   = (state_ff == S_LOOK) ? ALU_INC : ALU_DEC;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      tid_in      = tid_ff;
      fu_in       = fu_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      olen_in     = olen_ff;
      wlen_in     = wlen_ff;
      fin_kind_in = fin_kind_ff;
      fin_task_in = fin_task_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;
      rsp_task_in = rsp_task_ff;
      rsp_last_in = rsp_last_ff;

      oln_we    = 1'b0;
      oln_waddr = tid_idx;
      oln_wdata = olen_eff + OLEN_W'(1);
      pc_we     = 1'b0;
      pc_waddr  = fu_idx;
      pc_wdata  = alu_res.sum;
      wln_we    = 1'b0;
      wln_waddr = fu_idx;
      wln_wdata = wlen_eff + WLEN_W'(1);
      ols_we    = 1'b0;
      ols_waddr = OL_AW'(int'(tid_idx) * MAX_OUTS + int'(olen_eff));
      ols_wdata = fu_ff;
      wls_we    = 1'b0;
      wls_waddr = WL_AW'(int'(fu_idx) * MAX_WAITERS + int'(wlen_eff));
      wls_wdata = tid_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               tid_in   = req_task_id;
               fu_in    = req_future_id;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            fin_kind_in = KIND_DONE;
            fin_task_in = '0;
            state_in    = S_FINAL;
            if (tid_bad || ((cmd_ff == CMD_LINK_OUT || cmd_ff == CMD_LINK_WAIT) && fid_bad)) begin
               fin_kind_in = KIND_ERROR;
            end else begin
               case (cmd_ff)
                  CMD_LINK_OUT: begin
                     if (olen_eff >= OLEN_W'(MAX_OUTS) || alu_res.at_max) begin
                        fin_kind_in = KIND_ERROR;
                     end else begin
                        ols_we = 1'b1;
                        oln_we = 1'b1;
                        pc_we  = 1'b1;
                     end
                  end
                  CMD_LINK_WAIT: begin
                     if (wlen_eff >= WLEN_W'(MAX_WAITERS)) begin
                        fin_kind_in = KIND_ERROR;
                     end else begin
                        wls_we = 1'b1;
                        wln_we = 1'b1;
                     end
                  end
                  CMD_ISSUE: begin
                     fin_kind_in = KIND_ISSUE;
                     fin_task_in = tid_ff;
                  end
                  default: begin
                     olen_in = olen_eff;
                     idx_in  = '0;
                     if (olen_eff != '0) begin
                        state_in = S_OREAD;
                     end
                  end
               endcase
            end
         end
         S_OREAD: begin
            state_in = S_FREAD;
         end
         S_FREAD: begin
            fu_in    = ols_q;
            state_in = S_FDEC;
         end
         S_FDEC: begin
            if (fu_ok && !alu_res.at_zero) begin
               pc_we = 1'b1;
            end
            if (fu_ok && !alu_res.at_zero && alu_res.sum_zero && wlen_eff != '0) begin
               // future fires: release its waiters
               wlen_in  = wlen_eff;
               j_in     = '0;
               state_in = S_WREAD;
            end else if (last_out) begin
               oln_we    = 1'b1;
               oln_wdata = '0;
               state_in  = S_FINAL;
            end else begin
               idx_in   = idx_nxt;
               state_in = S_OREAD;
            end
         end
         S_WREAD: begin
            state_in = S_WEMIT;
         end
         S_WEMIT: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ISSUE;
               rsp_task_in  = wls_q;
               rsp_last_in  = 1'b0;
               if (j_nxt >= wlen_ff) begin
                  wln_we    = 1'b1;
                  wln_wdata = '0;
                  if (last_out) begin
                     oln_we    = 1'b1;
                     oln_wdata = '0;
                     state_in  = S_FINAL;
                  end else begin
                     idx_in   = idx_nxt;
                     state_in = S_OREAD;
                  end
               end else begin
                  j_in     = j_nxt;
                  state_in = S_WREAD;
               end
            end
         end
         S_FINAL: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = fin_kind_ff;
               rsp_task_in  = fin_task_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         oln_vld_ff   <= '0;
         pc_vld_ff    <= '0;
         wln_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (oln_we) begin
            oln_vld_ff[oln_waddr] <= 1'b1;
         end
         if (pc_we) begin
            pc_vld_ff[pc_waddr] <= 1'b1;
         end
         if (wln_we) begin
            wln_vld_ff[wln_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tid_ff       <= tid_in;
      fu_ff        <= fu_in;
      idx_ff       <= idx_in;
      j_ff         <= j_in;
      olen_ff      <= olen_in;
      wlen_ff      <= wlen_in;
      fin_kind_ff  <= fin_kind_in;
      fin_task_ff  <= fin_task_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_last_ff  <= rsp_last_in;
      // valid flags follow the table reads
      oln_vld_q_ff <= oln_vld_ff[oln_raddr];
      pc_vld_q_ff  <= pc_vld_ff[pc_raddr];
      wln_vld_q_ff <= wln_vld_ff[wln_raddr];
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_issued_task = rsp_task_ff;
   assign rsp_last_item   = rsp_last_ff;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the task dependency trigger
// Drives link, issue and complete commands on the req_ channel and checks
// every rsp_ transaction against a local model of the task and future
// tables. A directed table covers empty and full lists, a future linked
// twice and waiter release. Two bursts follow: one fans out to the longest
// result run and one drives a pending count to its ceiling. Random command
// sequences close the run under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tdt_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int END_CYCLES     = 40;
   localparam int PHASE_ITEMS    = 64;
   localparam int POOL_SIZE      = 6;

   localparam logic [TASK_W-1:0] FANOUT_TASK = 6'd50;
   localparam logic [FUT_W-1:0]  CAP_FUTURE  = 6'd37;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TASK_W-1:0] issued;
      logic              last;
   } trig_result_type;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [TASK_W-1:0] tid;
      logic [FUT_W-1:0]  fid;
      bit                typed;
      logic [KIND_W-1:0] kind;
      logic [TASK_W-1:0] issued;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd = CMD_ISSUE;
   logic [TASK_W-1:0] req_task_id = '0;
   logic [FUT_W-1:0]  req_future_id = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_result_kind;
   logic [TASK_W-1:0] rsp_issued_task;
   logic              rsp_last_item;

   // local copy of the trigger tables
   logic [CNT_W-1:0]  fut_count   [NUM_FUTURES];
   logic [TASK_W-1:0] fut_waiters [NUM_FUTURES][MAX_WAITERS];
   logic [WLEN_W-1:0] fut_wlen    [NUM_FUTURES];
   logic [FUT_W-1:0]  task_outs   [NUM_TASKS][MAX_OUTS];
   logic [OLEN_W-1:0] task_olen   [NUM_TASKS];

   trig_result_type due_results[$];
   trig_result_type step_results[$];
   stim_row_type    directed_rows[$];
   trig_result_type want;

   logic [FUT_W-1:0] fanout_futs [MAX_OUTS] = '{6'd3, 6'd17, 6'd40, 6'd58};

   int  err_count = 0;
   int  cmds_sent = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  hold_token = 1'b0;
   bit  hold_seen = 1'b0;

   task_dependency_trigger u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_task_id     (req_task_id),
      .req_future_id   (req_future_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_issued_task (rsp_issued_task),
      .rsp_last_item   (rsp_last_item)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void note_result(input logic [KIND_W-1:0] kind,
                                       input logic [TASK_W-1:0] issued,
                                       input logic last);
      step_results.push_back({kind, issued, last});
   endfunction

   // Works out the results of one command and updates the tables.
   function automatic void predict_trigger(input logic [CMD_W-1:0]  cmd,
                                           input logic [TASK_W-1:0] tid,
                                           input logic [FUT_W-1:0]  fid);
      logic [FUT_W-1:0] fu;
      step_results.delete();
      if (tid >= NUM_TASKS || (cmd != CMD_ISSUE && cmd != CMD_COMPLETE
                               && fid >= NUM_FUTURES)) begin
         note_result(KIND_ERROR, '0, 1'b1);
         return;
      end
      case (cmd)
         CMD_LINK_OUT: begin
            if (task_olen[tid] >= MAX_OUTS || fut_count[fid] >= COUNT_MAX) begin
               note_result(KIND_ERROR, '0, 1'b1);
            end else begin
               task_outs[tid][task_olen[tid]] = fid;
               task_olen[tid]++;
               fut_count[fid]++;
               note_result(KIND_DONE, '0, 1'b1);
            end
         end
         CMD_LINK_WAIT: begin
            if (fut_wlen[fid] >= MAX_WAITERS) begin
               note_result(KIND_ERROR, '0, 1'b1);
            end else begin
               fut_waiters[fid][fut_wlen[fid]] = tid;
               fut_wlen[fid]++;
               note_result(KIND_DONE, '0, 1'b1);
            end
         end
         CMD_ISSUE: begin
            note_result(KIND_ISSUE, tid, 1'b1);
         end
         default: begin
            for (int i = 0; i < int'(task_olen[tid]); i++) begin
               fu = task_outs[tid][i];
               // a count already at zero is left alone and does not fire
               if (fut_count[fu] != '0) begin
                  fut_count[fu]--;
                  if (fut_count[fu] == '0) begin
                     for (int j = 0; j < int'(fut_wlen[fu]); j++)
                        note_result(KIND_ISSUE, fut_waiters[fu][j], 1'b0);
                     fut_wlen[fu] = '0;
                  end
               end
            end
            task_olen[tid] = '0;
            note_result(KIND_DONE, '0, 1'b1);
         end
      endcase
   endfunction

   task automatic add_row(input logic [CMD_W-1:0]  cmd,
                          input logic [TASK_W-1:0] tid,
                          input logic [FUT_W-1:0]  fid,
                          input bit                typed,
                          input logic [KIND_W-1:0] kind,
                          input logic [TASK_W-1:0] issued);
      stim_row_type row;
      row.cmd    = cmd;
      row.tid    = tid;
      row.fid    = fid;
      row.typed  = typed;
      row.kind   = kind;
      row.issued = issued;
      directed_rows.push_back(row);
   endtask

   // Offers one command and books its results once the transaction is taken.
   task automatic send_item(input logic [CMD_W-1:0]  cmd,
                            input logic [TASK_W-1:0] tid,
                            input logic [FUT_W-1:0]  fid,
                            input bit                typed = 1'b0,
                            input logic [KIND_W-1:0] typed_kind = KIND_DONE,
                            input logic [TASK_W-1:0] typed_issued = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_task_id   <= tid;
      req_future_id <= fid;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_trigger(cmd, tid, fid);
      if (typed)
         due_results.push_back({typed_kind, typed_issued, 1'b1});
      else
         foreach (step_results[k])
            due_results.push_back(step_results[k]);
      cmds_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
   endtask

   // Mostly link/complete sequences over a small pool of futures, some noise.
   task automatic run_mixed(input int n_items);
      logic [FUT_W-1:0]  pool [POOL_SIZE];
      logic [TASK_W-1:0] tid;
      logic [FUT_W-1:0]  fid;
      int                stop_at;
      int                links;
      foreach (pool[p])
         pool[p] = FUT_W'($urandom_range(NUM_FUTURES - 1));
      stop_at = cmds_sent + n_items;
      while (cmds_sent < stop_at) begin
         if ($urandom_range(99) < 20) begin
            send_item(CMD_W'($urandom_range(3)), TASK_W'($urandom_range(NUM_TASKS - 1)),
                      FUT_W'($urandom_range(NUM_FUTURES - 1)));
         end else begin
            tid   = TASK_W'($urandom_range(NUM_TASKS - 1));
            links = int'($urandom_range(MAX_OUTS, 1));
            repeat (links) begin
               fid = pool[$urandom_range(POOL_SIZE - 1)];
               if ($urandom_range(99) < 60)
                  send_item(CMD_LINK_WAIT, TASK_W'($urandom_range(NUM_TASKS - 1)), fid);
               send_item(CMD_LINK_OUT, tid, fid);
            end
            if ($urandom_range(3) == 0)
               send_item(CMD_ISSUE, tid, FUT_W'($urandom_range(NUM_FUTURES - 1)));
            // some tasks are left open so that counts build up
            if ($urandom_range(4) != 0)
               send_item(CMD_COMPLETE, tid, FUT_W'($urandom_range(NUM_FUTURES - 1)));
         end
      end
   endtask

   // Result side: check each transaction, then choose next cycle's stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_seen = hold_token;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               err_count++;
               $error("unexpected result: result_kind %0d issued_task %0d last_item %0d",
                      rsp_result_kind, rsp_issued_task, rsp_last_item);
            end else begin
               want = due_results.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  err_count++;
                  $error("result_kind: expected %0d, got %0d", want.kind, rsp_result_kind);
               end
               if (rsp_issued_task !== want.issued) begin
                  err_count++;
                  $error("issued_task: expected %0d, got %0d", want.issued, rsp_issued_task);
               end
               if (rsp_last_item !== want.last) begin
                  err_count++;
                  $error("last_item: expected %0d, got %0d", want.last, rsp_last_item);
               end
            end
         end
         if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int t;
      foreach (fut_count[i]) begin
         fut_count[i] = '0;
         fut_wlen[i]  = '0;
      end
      foreach (task_olen[i])
         task_olen[i] = '0;

      //       cmd            task    future  typed kind        issued
      add_row(CMD_ISSUE,     6'd0,  6'd63, 1'b1, KIND_ISSUE, 6'd0);
      add_row(CMD_ISSUE,     6'd63, 6'd0,  1'b1, KIND_ISSUE, 6'd63);
      add_row(CMD_COMPLETE,  6'd5,  6'd63, 1'b1, KIND_DONE,  6'd0);   // nothing linked
      add_row(CMD_LINK_OUT,  6'd63, 6'd63, 1'b1, KIND_DONE,  6'd0);
      add_row(CMD_LINK_OUT,  6'd63, 6'd0,  1'b1, KIND_DONE,  6'd0);
      add_row(CMD_LINK_OUT,  6'd63, 6'd63, 1'b1, KIND_DONE,  6'd0);   // same future again
      add_row(CMD_LINK_OUT,  6'd63, 6'd1,  1'b1, KIND_DONE,  6'd0);
      add_row(CMD_LINK_OUT,  6'd63, 6'd2,  1'b1, KIND_ERROR, 6'd0);   // output list full
      add_row(CMD_LINK_WAIT, 6'd0,  6'd63, 1'b1, KIND_DONE,  6'd0);
      add_row(CMD_LINK_WAIT, 6'd63, 6'd63, 1'b1, KIND_DONE,  6'd0);
      add_row(CMD_LINK_WAIT, 6'd42, 6'd0,  1'b1, KIND_DONE,  6'd0);
      add_row(CMD_COMPLETE,  6'd63, 6'd21, 1'b0, KIND_DONE,  6'd0);
      add_row(CMD_COMPLETE,  6'd63, 6'd0,  1'b1, KIND_DONE,  6'd0);   // list already cleared
      add_row(CMD_LINK_OUT,  6'd62, 6'd63, 1'b1, KIND_DONE,  6'd0);
      add_row(CMD_COMPLETE,  6'd62, 6'd0,  1'b1, KIND_DONE,  6'd0);   // fires, no waiters
      for (t = 1; t <= MAX_WAITERS; t++)
         add_row(CMD_LINK_WAIT, TASK_W'(t), 6'd10, 1'b1, KIND_DONE, 6'd0);
      add_row(CMD_LINK_WAIT, 6'd9, 6'd10, 1'b1, KIND_ERROR, 6'd0);    // waiter list full

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r])
         send_item(directed_rows[r].cmd, directed_rows[r].tid, directed_rows[r].fid,
                   directed_rows[r].typed, directed_rows[r].kind, directed_rows[r].issued);

      // full fan-out: four futures, eight waiters each, released by one complete
      stall_pct = 61;
      foreach (fanout_futs[f]) begin
         for (t = 0; t <= MAX_WAITERS; t++)
            send_item(CMD_LINK_WAIT, TASK_W'($urandom_range(NUM_TASKS - 1)), fanout_futs[f]);
         send_item(CMD_LINK_OUT, FANOUT_TASK, fanout_futs[f]);
      end
      send_item(CMD_COMPLETE, FANOUT_TASK, FUT_W'($urandom_range(NUM_FUTURES - 1)));

      // pending count up to its ceiling, then back down to release the waiters
      stall_pct     = 0;
      send_idle_pct = 61;
      send_item(CMD_LINK_WAIT, 6'd11, CAP_FUTURE);
      send_item(CMD_LINK_WAIT, 6'd22, CAP_FUTURE);
      for (t = 0; t < 32; t++)
         repeat (MAX_OUTS)
            send_item(CMD_LINK_OUT, TASK_W'(t), CAP_FUTURE);
      for (t = 0; t < 32; t++)
         send_item(CMD_COMPLETE, TASK_W'(t), FUT_W'($urandom_range(NUM_FUTURES - 1)));
      drain_results();

      // receiver holds off for a long stretch while commands keep coming
      send_idle_pct = 0;
      hold_token   <= ~hold_token;
      run_mixed(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 61;
      run_mixed(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 0;
      stall_pct     = 61;
      run_mixed(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 33;
      stall_pct     = 33;
      run_mixed(PHASE_ITEMS);
      drain_results();

      repeat (END_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         err_count++;
         $error("%0d expected results never arrived", due_results.size());
      end
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
design/tdt_pkg.sv
design/tdt_ram.sv
design/tdt_alu.sv
design/task_dependency_trigger.sv
test/tb_top.sv
